>>> rtl/core/text_cell_terminal_defines.svh
// Assertion macros used by the terminal's top-level RTL.
// They expect aclk and aresetn in scope at the point of use.
`ifndef TEXT_CELL_TERMINAL_DEFINES_SVH
`define TEXT_CELL_TERMINAL_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define TCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tct_pkg.sv
// Shared types and constants of the text cell terminal.
// Used by tct_ctrl, tct_datapath and text_cell_terminal; no dependencies.
package tct_pkg;

    // Command codes carried in s_tuser.
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_GOTO  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

    // Stream widths.
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned CELL_W    = 9;

    // Datapath operation codes issued by the controller.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_EXEC  = 3'd1;
    localparam logic [2:0] OP_COPY  = 3'd2;
    localparam logic [2:0] OP_BLANK = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_ZERO  = 3'd5;

    // Controller to datapath commands.
    typedef struct packed {
        logic       cap_in;
        logic [2:0] op;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       load_out;
    } tct_ctrl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic go_scroll;
        logic go_clear;
        logic copy_last;
        logic fill_last;
    } tct_stat_t;

endpackage

>>> rtl/core/text_cell_terminal.sv
// Top level of the text cell terminal: character grid with cursor.
// Depends on tct_pkg, tct_ctrl, tct_datapath and text_cell_terminal_defines.svh.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata, s_tuser (command)
//  m_       out        m_tvalid / m_tready  m_tdata (cursor, cell, scroll flag)
//  cfg_     in         cfg_wr_en            cfg_wr_data (text color)
//
// Put, goto and read pass from transfer to result through capture, execute and result load.
// A scroll adds a row copy through the memory read and write ports, then bottom-row blanking.
// Clear adds fill writes of every cell through the memory write port.
// After reset a clearing pass zeroes every cell of the grid; s_tready stays low until it ends.
// One command is worked at a time; a waiting result does not block the next input transfer.
`include "text_cell_terminal_defines.svh"

module text_cell_terminal #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: char_code[7:0], target_column[15:8], target_row[23:16].
    input  logic [tct_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [tct_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: cursor_column[6:0], cursor_row[11:7], cell_char[19:12],
    // cell_highlight[20], did_scroll[21], zero[23:22].
    output logic [tct_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data
);
    import tct_pkg::*;

    tct_ctrl_t ctrl;
    tct_stat_t stat;

    // Sequencer.
    tct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    // Grid, cursor and result register.
    tct_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .stat        (stat),
        .m_tdata     (m_tdata)
    );

    // A result always reports a cursor column inside the grid.
    `TCT_ASSERT_NOW(a_col_in_grid, m_tvalid, 8'(m_tdata[6:0]) < 8'(COLUMNS), "column outside grid")

    // A scroll always leaves the cursor at column 0.
    `TCT_ASSERT_NOW(a_scroll_home, m_tvalid && m_tdata[21], m_tdata[6:0] == 7'd0, "scroll off column 0")

    // An input transfer starts work, so the block is busy in the next cycle.
    `TCT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after a transfer")

endmodule

>>> rtl/core/tct_ctrl.sv
// Controller state machine of the text cell terminal.
// Depends on tct_pkg; drives tct_datapath through tct_ctrl_t commands.
module tct_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output tct_pkg::tct_ctrl_t ctrl,
    input  tct_pkg::tct_stat_t stat
);
    import tct_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        ctrl.op        = OP_NONE;

        // The result register empties when its transfer completes.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                ctrl.op      = OP_ZERO;
                ctrl.cnt_inc = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.cap_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctrl.op      = OP_EXEC;
                ctrl.cnt_clr = 1'b1;
                if (stat.go_clear) begin
                    state_next = ST_FILL;
                end else if (stat.go_scroll) begin
                    state_next = ST_COPY;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY: begin
                ctrl.op = OP_COPY;
                // The last copy cycle leaves the counter on the first bottom-row cell.
                if (stat.copy_last) begin
                    state_next = ST_BLANK;
                end else begin
                    ctrl.cnt_inc = 1'b1;
                end
            end
            ST_BLANK: begin
                ctrl.op      = OP_BLANK;
                ctrl.cnt_inc = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL: begin
                ctrl.op      = OP_CLEAR;
                ctrl.cnt_inc = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> rtl/core/tct_datapath.sv
// Datapath of the text cell terminal: cell memory, cursor, sweep counter, result register.
// Depends on tct_pkg; sequenced by tct_ctrl.
module tct_datapath #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 30
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tct_pkg::FUNC_W-1:0]     s_tuser,
    input  logic [tct_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           cfg_wr_en,
    input  logic [7:0]                     cfg_wr_data,
    input  tct_pkg::tct_ctrl_t             ctrl,
    output tct_pkg::tct_stat_t             stat,
    output logic [tct_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tct_pkg::*;

    localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
    localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
    localparam int unsigned COL_W      = $clog2(COLUMNS);
    localparam int unsigned ROW_W      = $clog2(ROWS);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [8:0]        COL_LIM   = 9'(COLUMNS);
    localparam logic [8:0]        ROW_LIM   = 9'(ROWS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS);

    // Captured command.
    logic [1:0] func_reg;
    logic [7:0] code_reg;
    logic [7:0] tcol_reg;
    logic [7:0] trow_reg;

    logic [7:0]        text_color_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic              scroll_reg;
    logic              hit_reg;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;

    logic              hilite;
    logic              is_put;
    logic              is_lf;
    logic              is_cr;
    logic              col_wrap;
    logic              row_bottom;
    logic              read_hit;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] tgt_addr;
    logic [ADDR_W:0]   src_addr;

    // Command capture on an input transfer.
    always_ff @(posedge aclk) begin
        if (ctrl.cap_in) begin
            func_reg <= s_tuser;
            code_reg <= s_tdata[7:0];
            tcol_reg <= s_tdata[15:8];
            trow_reg <= s_tdata[23:16];
        end
    end

    // Color register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= TEXT_COLOR_RESET;
        end else if (cfg_wr_en) begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // Command decode against the current cursor.
    assign hilite     = |text_color_reg[7:4];
    assign is_put     = (func_reg == FUNC_PUT);
    assign is_lf      = (code_reg == CHAR_LF);
    assign is_cr      = (code_reg == CHAR_CR);
    assign col_wrap   = (col_reg == COL_LAST);
    assign row_bottom = (row_reg == ROW_LAST);
    assign read_hit   = (func_reg == FUNC_READ) && ({1'b0, tcol_reg} < COL_LIM)
                        && ({1'b0, trow_reg} < ROW_LIM);
    assign cur_addr   = ADDR_W'(ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg));
    assign tgt_addr   = ADDR_W'(ADDR_W'(trow_reg) * COLS_A + ADDR_W'(tcol_reg));
    assign src_addr   = {1'b0, cnt_reg} + {1'b0, COLS_A};

    assign stat.go_clear  = (func_reg == FUNC_CLEAR);
    assign stat.go_scroll = is_put && row_bottom && (is_lf || (!is_cr && col_wrap));
    assign stat.copy_last = (cnt_reg == COPY_LAST);
    assign stat.fill_last = (cnt_reg == CELL_LAST);

    // Cursor update for the executed command; a scroll leaves column 0 of the last row.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        case (func_reg)
            FUNC_PUT: begin
                if (is_lf) begin
                    if (row_bottom) begin
                        col_next = '0;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else if (is_cr) begin
                    col_next = '0;
                end else if (col_wrap) begin
                    col_next = '0;
                    if (!row_bottom) begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            FUNC_GOTO: begin
                if ({1'b0, tcol_reg} < COL_LIM) begin
                    col_next = COL_W'(tcol_reg);
                end
                if ({1'b0, trow_reg} < ROW_LIM) begin
                    row_next = ROW_W'(trow_reg);
                end
            end
            FUNC_CLEAR: begin
                col_next = '0;
                row_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Cursor, result flags and sweep counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (ctrl.op == OP_EXEC) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (ctrl.cnt_clr) begin
                cnt_reg <= '0;
            end else if (ctrl.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_EXEC) begin
            scroll_reg <= stat.go_scroll;
            hit_reg    <= read_hit;
        end
    end

    // Memory port selection. The copy reads one row ahead and writes the cell
    // read in the previous cycle one row up.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tgt_addr;
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        case (ctrl.op)
            OP_EXEC: begin
                rd_en   = read_hit;
                wr_en   = is_put && !is_lf && !is_cr;
                wr_addr = cur_addr;
                wr_data = {hilite, code_reg};
            end
            OP_COPY: begin
                rd_en   = !stat.copy_last;
                rd_addr = src_addr[ADDR_W-1:0];
                wr_en   = (cnt_reg != '0);
                wr_addr = cnt_reg - 1'b1;
                wr_data = rd_data_reg;
            end
            OP_BLANK: begin
                wr_en   = 1'b1;
                wr_data = {hilite, CHAR_SPACE};
            end
            OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, CHAR_SPACE};
            end
            OP_ZERO: begin
                wr_en   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Cell memory with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_tdata <= {2'b00,
                        scroll_reg,
                        hit_reg & rd_data_reg[8],
                        hit_reg ? rd_data_reg[7:0] : 8'h00,
                        5'(row_reg),
                        7'(col_reg)};
        end
    end

endmodule

>>> bench/text_cell_terminal_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text cell terminal: streams commands, predicts each report
// with its own model of the grid and cursor, and checks every report transfer.
// Depends on tct_pkg and the text_cell_terminal RTL.
module text_cell_terminal_tb;
    import tct_pkg::*;

    localparam int unsigned COLUMNS      = 80;
    localparam int unsigned ROWS         = 30;
    localparam int unsigned CELL_COUNT   = COLUMNS * ROWS;
    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned IDLE_PCT     = 32;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 16;
    // Every command a full scroll with idle gaps, several times over.
    localparam longint TIMEOUT_NS = 150_000_000;

    // One command; func travels on s_tuser, the rest on s_tdata.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] target_row;
        logic [7:0] target_column;
        logic [7:0] char_code;
    } term_cmd_t;

    // One report, laid out as in m_tdata[21:0].
    typedef struct packed {
        logic       did_scroll;
        logic       cell_highlight;
        logic [7:0] cell_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_column;
    } term_report_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic [FUNC_W-1:0]      s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [7:0]             cfg_wr_data = '0;

    // Predictor state: grid cells (bit 8 highlight), cursor and text color.
    logic [8:0]   screen_cells [CELL_COUNT];
    logic [6:0]   model_col;
    logic [4:0]   model_row;
    logic [7:0]   model_color;

    term_cmd_t    command_backlog [$];
    term_report_t report_queue [$];
    logic         in_taken      = 1'b0;
    logic         steady_flow   = 1'b0;
    int unsigned  hold_requests = 0;
    int unsigned  hold_served   = 0;
    int unsigned  hold_left     = 0;
    int unsigned  error_count   = 0;

    text_cell_terminal #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A cell written with the current color: any high-nibble bit sets the highlight.
    function automatic logic [8:0] colored_cell(input logic [7:0] code);
        return {|model_color[7:4], code};
    endfunction

    // Moves the cursor down a row; on the last row the grid scrolls up. Returns 1 on scroll.
    function automatic logic line_feed();
        int i;
        if (int'(model_row) + 1 < ROWS) begin
            model_row = model_row + 1'b1;
            return 1'b0;
        end
        for (i = 0; i + COLUMNS < CELL_COUNT; i++) begin
            screen_cells[i] = screen_cells[i + COLUMNS];
        end
        for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_cells[i] = colored_cell(CHAR_SPACE);
        end
        model_col = '0;
        model_row = 5'(ROWS - 1);
        return 1'b1;
    endfunction

    // Applies one command to the model and returns the report it produces.
    function automatic term_report_t apply_command(input term_cmd_t cmd);
        term_report_t rep;
        logic [8:0]   cell_word;
        int           i;
        rep = '0;
        case (cmd.func)
            FUNC_PUT: begin
                if (cmd.char_code == CHAR_LF) begin
                    rep.did_scroll = line_feed();
                end else if (cmd.char_code == CHAR_CR) begin
                    model_col = '0;
                end else begin
                    screen_cells[model_row * COLUMNS + model_col] = colored_cell(cmd.char_code);
                    if (int'(model_col) + 1 >= COLUMNS) begin
                        model_col = '0;
                        rep.did_scroll = line_feed();
                    end else begin
                        model_col = model_col + 1'b1;
                    end
                end
            end
            FUNC_GOTO: begin
                // Each axis moves only when its target is inside the grid.
                if (cmd.target_column < COLUMNS) model_col = cmd.target_column[6:0];
                if (cmd.target_row < ROWS) model_row = cmd.target_row[4:0];
            end
            FUNC_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++) begin
                    screen_cells[i] = {1'b0, CHAR_SPACE};
                end
                model_col = '0;
                model_row = '0;
            end
            FUNC_READ: begin
                if (cmd.target_column < COLUMNS && cmd.target_row < ROWS) begin
                    cell_word = screen_cells[cmd.target_row * COLUMNS + cmd.target_column];
                    rep.cell_char      = cell_word[7:0];
                    rep.cell_highlight = cell_word[8];
                end
            end
            default: begin
            end
        endcase
        rep.cursor_column = model_col;
        rep.cursor_row    = model_row;
        return rep;
    endfunction

    // Command builders; fields a command ignores get random values.
    function automatic void queue_cmd(input logic [1:0] func, input logic [7:0] code,
                                      input logic [7:0] col, input logic [7:0] row);
        term_cmd_t cmd;
        cmd.func          = func;
        cmd.char_code     = code;
        cmd.target_column = col;
        cmd.target_row    = row;
        command_backlog.push_back(cmd);
    endfunction

    function automatic void put_char(input logic [7:0] code);
        queue_cmd(FUNC_PUT, code, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    function automatic void goto_cell(input logic [7:0] col, input logic [7:0] row);
        queue_cmd(FUNC_GOTO, 8'($urandom_range(255)), col, row);
    endfunction

    function automatic void read_cell(input logic [7:0] col, input logic [7:0] row);
        queue_cmd(FUNC_READ, 8'($urandom_range(255)), col, row);
    endfunction

    function automatic void clear_screen();
        queue_cmd(FUNC_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endfunction

    // Queues one short command sequence of a random kind; returns its length.
    function automatic int add_episode();
        int         start;
        int         kind;
        int         len;
        int         i;
        int         pick;
        int         row;
        logic [1:0] func;
        start = command_backlog.size();
        kind  = $urandom_range(99);
        if (kind < 40) begin
            // Text run at a random spot, with some line feeds and carriage returns.
            goto_cell(8'($urandom_range(COLUMNS - 1)), 8'($urandom_range(ROWS - 1)));
            len = $urandom_range(30, 1);
            for (i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 5) put_char(CHAR_LF);
                else if (pick < 10) put_char(CHAR_CR);
                else put_char(8'($urandom_range(255)));
            end
        end else if (kind < 55) begin
            // Reads, mostly inside the grid.
            len = $urandom_range(8, 2);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(99) < 80)
                    read_cell(8'($urandom_range(COLUMNS - 1)), 8'($urandom_range(ROWS - 1)));
                else
                    read_cell(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end else if (kind < 65) begin
            // Gotos with any target, so that either axis may be out of range.
            len = $urandom_range(4, 1);
            for (i = 0; i < len; i++) begin
                goto_cell(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end else if (kind < 80) begin
            // Scroll from the last row by a line feed or a wrap, then look at the moved rows.
            goto_cell(8'($urandom_range(COLUMNS - 1)), 8'(ROWS - 1));
            len = $urandom_range(5);
            for (i = 0; i < len; i++) put_char(8'($urandom_range(126, 32)));
            if ($urandom_range(1) == 0) begin
                put_char(CHAR_LF);
            end else begin
                goto_cell(8'($urandom_range(COLUMNS - 1, COLUMNS - 6)), 8'(ROWS - 1));
                for (i = 0; i < 6; i++) put_char(8'($urandom_range(126, 32)));
            end
            len = $urandom_range(5, 3);
            for (i = 0; i < len; i++) begin
                read_cell(8'($urandom_range(COLUMNS - 1)), 8'(ROWS - 1 - $urandom_range(1)));
            end
        end else if (kind < 90) begin
            // Noise: any command with any fields; clears are thinned out.
            len = $urandom_range(6, 1);
            for (i = 0; i < len; i++) begin
                func = 2'($urandom_range(3));
                if (func == FUNC_CLEAR && $urandom_range(7) != 0) func = FUNC_READ;
                queue_cmd(func, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            end
        end else if (kind < 95) begin
            // Wrap at the end of a row above the last one.
            row = $urandom_range(ROWS - 2);
            goto_cell(8'(COLUMNS - 1), 8'(row));
            put_char(8'($urandom_range(255, 14)));
            read_cell(8'(COLUMNS - 1), 8'(row));
        end else begin
            // Clear, then reads of the blank grid.
            clear_screen();
            for (i = 0; i < 3; i++) begin
                read_cell(8'($urandom_range(COLUMNS - 1)), 8'($urandom_range(ROWS - 1)));
            end
        end
        return command_backlog.size() - start;
    endfunction

    // Writes the text color; only called while the block is idle.
    task automatic write_color(input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        model_color = value;
    endtask

    // Waits until every queued command has been sent and every report has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (command_backlog.size() != 0 || s_tvalid || report_queue.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Command driver: offers the next command once the current one has been taken.
    always @(negedge aclk) begin : feed_commands
        term_cmd_t next_cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (command_backlog.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                next_cmd = command_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_cmd.func;
                s_tdata  <= {next_cmd.target_row, next_cmd.target_column, next_cmd.char_code};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Report receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on each command transfer and checks each report transfer.
    always @(posedge aclk) begin : check_reports
        term_report_t got;
        term_report_t want;
        term_cmd_t    cmd;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[21:0];
            if (report_queue.size() == 0) begin
                $error("report transfer with no command pending: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = report_queue.pop_front();
                check_field("cursor_column", 32'(want.cursor_column), 32'(got.cursor_column));
                check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
                check_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
                check_field("cell_highlight", 32'(want.cell_highlight),
                            32'(got.cell_highlight));
                check_field("did_scroll", 32'(want.did_scroll), 32'(got.did_scroll));
                check_field("zero padding", 32'd0, 32'(m_tdata[23:22]));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            cmd.func          = s_tuser;
            cmd.char_code     = s_tdata[7:0];
            cmd.target_column = s_tdata[15:8];
            cmd.target_row    = s_tdata[23:16];
            report_queue.push_back(apply_command(cmd));
        end
    end

    // Run timeout.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus sequence.
    initial begin : stimulus
        int         phase;
        int         added;
        logic [7:0] color;
        for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = '0;
        model_col   = '0;
        model_row   = '0;
        model_color = TEXT_COLOR_RESET;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset color: reads of the zeroed grid and out of range,
        // character extremes, CR and LF, partial gotos, wrap and line feed scrolls, clear.
        read_cell(8'd0, 8'd0);
        read_cell(8'(COLUMNS), 8'd0);
        read_cell(8'd0, 8'(ROWS));
        read_cell(8'hff, 8'hff);
        put_char(8'h41);
        put_char(8'hff);
        put_char(8'h00);
        put_char(CHAR_CR);
        put_char(CHAR_LF);
        read_cell(8'd0, 8'd0);
        goto_cell(8'(COLUMNS), 8'd5);
        goto_cell(8'd3, 8'(ROWS));
        goto_cell(8'hff, 8'hff);
        goto_cell(8'(COLUMNS - 1), 8'(ROWS - 1));
        put_char(8'h5a);
        read_cell(8'(COLUMNS - 1), 8'(ROWS - 2));
        read_cell(8'd0, 8'(ROWS - 1));
        put_char(8'h71);
        put_char(CHAR_LF);
        clear_screen();
        read_cell(8'd5, 8'd5);
        wait_drained();

        // Highlight color: written cells and the blank row of a scroll carry the highlight.
        write_color(8'hf0);
        put_char(8'h48);
        read_cell(8'd0, 8'd0);
        goto_cell(8'd7, 8'(ROWS - 1));
        put_char(CHAR_LF);
        read_cell(8'd7, 8'(ROWS - 1));
        wait_drained();

        // Random phases, each under its own color; the sender pauses between phases.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       color = 8'h00;
                1:       color = 8'hff;
                2:       color = 8'h10;
                3:       color = 8'h0f;
                4:       color = 8'h80;
                default: color = 8'($urandom_range(255));
            endcase
            write_color(color);
            steady_flow = (phase == 2);
            if (phase == 3) hold_requests++;
            added = 0;
            while (added < RANDOM_ITEMS / PHASES) added += add_episode();
            wait_drained();
        end
        steady_flow = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && report_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tct_pkg.sv
rtl/core/tct_ctrl.sv
rtl/core/tct_datapath.sv
rtl/core/text_cell_terminal.sv
bench/text_cell_terminal_tb.sv
